// ----- design/apisp_pkg.sv -----
// shared types and constants of the animated palette image stream parser
`default_nettype none

package apisp_pkg;

  // record kinds, also used as the command code between front and back
  typedef enum logic [2:0] {
    KIND_TAG     = 3'd0,
    KIND_LCOUNT  = 3'd1,
    KIND_KEY     = 3'd2,
    KIND_RES     = 3'd3,
    KIND_PALETTE = 3'd4,
    KIND_FCOUNT  = 3'd5,
    KIND_PIXEL   = 3'd6
  } record_kind_e;

  // header parser phases
  typedef enum logic [2:0] {
    PH_TAG    = 3'd0,
    PH_LCOUNT = 3'd1,
    PH_KEYS   = 3'd2,
    PH_RES    = 3'd3,
    PH_PCOUNT = 3'd4,
    PH_PAL    = 3'd5,
    PH_FCOUNT = 3'd6,
    PH_PIX    = 3'd7
  } phase_e;

  // file signature bytes, first byte first
  localparam logic [7:0] SIG_BYTES [4] = '{8'h56, 8'h54, 8'h4E, 8'h43};

  // classified word from front to back
  typedef struct packed {
    record_kind_e kind;
    logic         match;
    logic [7:0]   layer;
    logic [23:0]  holder;
    logic [7:0]   data;
  } cmd_t;

  // layer with pixels: number and resolution
  typedef struct packed {
    logic [7:0]  idx;
    logic [15:0] w;
    logic [15:0] h;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

  // one result record
  typedef struct packed {
    record_kind_e kind;
    logic         match;
    logic [7:0]   layer;
    logic [7:0]   frame;
    logic [31:0]  index;
    logic [15:0]  va;
    logic [15:0]  vb;
    logic [7:0]   vc;
    logic         last;
  } rec_t;

endpackage

`default_nettype wire

// ----- design/apisp_ram.sv -----
// generic single-write, single-read ram with registered read
`default_nettype none

module apisp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/apisp_front.sv -----
// front: header parser that turns file bytes into classified words
`default_nettype none

module apisp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          start_i,
  output logic               push_o,
  output apisp_pkg::cmd_t    cmd_o
);

  import apisp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  bif_q, bif_d;
  logic [23:0] hold_q, hold_d;
  logic        ok_q, ok_d;
  logic [7:0]  lt_q, lt_d;
  logic [7:0]  lc_q, lc_d;
  logic [7:0]  pt_q, pt_d;
  logic [7:0]  pc_q, pc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      bif_q   <= 2'd0;
      hold_q  <= 24'd0;
      ok_q    <= 1'b1;
      lt_q    <= 8'd0;
      lc_q    <= 8'd0;
      pt_q    <= 8'd0;
      pc_q    <= 8'd0;
    end else begin
      phase_q <= phase_d;
      bif_q   <= bif_d;
      hold_q  <= hold_d;
      ok_q    <= ok_d;
      lt_q    <= lt_d;
      lc_q    <= lc_d;
      pt_q    <= pt_d;
      pc_q    <= pc_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    bif_d   = bif_q;
    hold_d  = hold_q;
    ok_d    = ok_q;
    lt_d    = lt_q;
    lc_d    = lc_q;
    pt_d    = pt_q;
    pc_d    = pc_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    if (accept_i) begin
      // a start byte restarts the parser and is the first signature byte
      if (start_i) begin
        phase_d = PH_TAG;
        bif_d   = 2'd0;
        hold_d  = 24'd0;
        ok_d    = 1'b1;
        lt_d    = 8'd0;
        lc_d    = 8'd0;
        pt_d    = 8'd0;
        pc_d    = 8'd0;
      end
      cmd_o.data   = byte_i;
      cmd_o.layer  = lc_d;
      cmd_o.holder = hold_d;
      unique case (phase_d)
        PH_TAG: begin
          if (byte_i != SIG_BYTES[bif_d]) begin
            ok_d = 1'b0;
          end
          if (bif_d != 2'd3) begin
            bif_d = bif_d + 2'd1;
          end else begin
            bif_d       = 2'd0;
            push_o      = 1'b1;
            cmd_o.kind  = KIND_TAG;
            cmd_o.match = ok_d;
            phase_d     = PH_LCOUNT;
          end
        end
        PH_LCOUNT: begin
          lt_d       = byte_i;
          lc_d       = 8'd0;
          push_o     = 1'b1;
          cmd_o.kind = KIND_LCOUNT;
          phase_d    = (byte_i == 8'd0) ? PH_PCOUNT : PH_KEYS;
        end
        PH_KEYS: begin
          push_o     = 1'b1;
          cmd_o.kind = KIND_KEY;
          lc_d       = lc_d + 8'd1;
          if (lc_d >= lt_d) begin
            lc_d    = 8'd0;
            phase_d = PH_RES;
          end
        end
        PH_RES: begin
          if (bif_d != 2'd3) begin
            hold_d[{bif_d, 3'b000} +: 8] = byte_i;
            bif_d = bif_d + 2'd1;
          end else begin
            bif_d      = 2'd0;
            push_o     = 1'b1;
            cmd_o.kind = KIND_RES;
            hold_d     = 24'd0;
            lc_d       = lc_d + 8'd1;
            if (lc_d >= lt_d) begin
              lc_d    = 8'd0;
              phase_d = PH_PCOUNT;
            end
          end
        end
        PH_PCOUNT: begin
          // stored, but no record for this byte
          pt_d    = byte_i;
          pc_d    = 8'd0;
          phase_d = (byte_i == 8'd0) ? PH_FCOUNT : PH_PAL;
        end
        PH_PAL: begin
          if (bif_d != 2'd3) begin
            hold_d[{bif_d, 3'b000} +: 8] = byte_i;
            bif_d = bif_d + 2'd1;
          end else begin
            bif_d      = 2'd0;
            push_o     = 1'b1;
            cmd_o.kind = KIND_PALETTE;
            hold_d     = 24'd0;
            pc_d       = pc_d + 8'd1;
            if (pc_d >= pt_d) begin
              phase_d = PH_FCOUNT;
            end
          end
        end
        PH_FCOUNT: begin
          push_o     = 1'b1;
          cmd_o.kind = KIND_FCOUNT;
          phase_d    = PH_PIX;
        end
        PH_PIX: begin
          // every later byte goes to the back, which drops those past the end
          push_o     = 1'b1;
          cmd_o.kind = KIND_PIXEL;
        end
        default: begin
          phase_d = PH_TAG;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/apisp_cmd_fifo.sv -----
// two-entry queue of classified words between front and back
`default_nettype none

module apisp_cmd_fifo (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire apisp_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output apisp_pkg::cmd_t cmd_o
);

  import apisp_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rptr_q];

endmodule

`default_nettype wire

// ----- design/apisp_back.sv -----
// back: formats records, keeps the layer chain and walks the pixel bytes
`default_nettype none

module apisp_back #(
  parameter int unsigned MAX_LAYERS = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  input  wire apisp_pkg::cmd_t cmd_i,
  output logic            cmd_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output apisp_pkg::rec_t rec_o
);

  import apisp_pkg::*;

  localparam int unsigned AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

  logic          out_vq, out_vd;
  rec_t          rec_q, rec_d;
  rec_t          rec_n;
  logic          emit;
  logic          take;

  // chain of layers with pixels, built while the resolutions arrive
  logic          any_q, any_d;
  res_t          first_q, first_d;
  logic [AW-1:0] prev_q, prev_d;
  logic [7:0]    last_q, last_d;

  // pixel walk
  logic          active_q, active_d;
  res_t          cur_q, cur_d;
  logic [7:0]    ftot_q, ftot_d;
  logic [7:0]    frame_q, frame_d;
  logic [15:0]   x_q, x_d;
  logic [15:0]   y_q, y_d;
  logic [31:0]   pidx_q, pidx_d;

  logic          we;
  logic [RES_W-1:0] link_rdata;
  res_t          link_next;
  logic [15:0]   w_res, h_res;
  logic          storable;

  apisp_ram #(
    .WIDTH (RES_W),
    .DEPTH (MAX_LAYERS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (prev_q),
    .wdata_i ({cmd_i.layer, w_res, h_res}),
    .raddr_i (cur_d.idx[AW-1:0]),
    .rdata_o (link_rdata)
  );

  assign link_next   = res_t'(link_rdata);
  assign cmd_ready_o = !out_vq || out_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign w_res       = cmd_i.holder[15:0];
  assign h_res       = {cmd_i.data, cmd_i.holder[23:16]};
  assign storable    = ({1'b0, cmd_i.layer} < 9'(MAX_LAYERS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq   <= 1'b0;
      any_q    <= 1'b0;
      first_q  <= '0;
      prev_q   <= '0;
      last_q   <= 8'd0;
      active_q <= 1'b0;
      cur_q    <= '0;
      ftot_q   <= 8'd0;
      frame_q  <= 8'd0;
      x_q      <= 16'd0;
      y_q      <= 16'd0;
      pidx_q   <= 32'd0;
    end else begin
      out_vq   <= out_vd;
      any_q    <= any_d;
      first_q  <= first_d;
      prev_q   <= prev_d;
      last_q   <= last_d;
      active_q <= active_d;
      cur_q    <= cur_d;
      ftot_q   <= ftot_d;
      frame_q  <= frame_d;
      x_q      <= x_d;
      y_q      <= y_d;
      pidx_q   <= pidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_comb begin
    out_vd   = out_vq && !out_ready_i;
    rec_d    = rec_q;
    any_d    = any_q;
    first_d  = first_q;
    prev_d   = prev_q;
    last_d   = last_q;
    active_d = active_q;
    cur_d    = cur_q;
    ftot_d   = ftot_q;
    frame_d  = frame_q;
    x_d      = x_q;
    y_d      = y_q;
    pidx_d   = pidx_q;
    we       = 1'b0;
    emit     = 1'b0;
    rec_n    = '0;
    rec_n.kind = cmd_i.kind;
    if (take) begin
      emit = 1'b1;
      unique case (cmd_i.kind)
        KIND_TAG: begin
          rec_n.match = cmd_i.match;
        end
        KIND_LCOUNT: begin
          rec_n.va = {8'd0, cmd_i.data};
          any_d    = 1'b0;
        end
        KIND_KEY: begin
          rec_n.layer = cmd_i.layer;
          rec_n.va    = {8'd0, cmd_i.data};
        end
        KIND_RES: begin
          rec_n.layer = cmd_i.layer;
          rec_n.va    = w_res;
          rec_n.vb    = h_res;
          // zero-area layers and layers past capacity stay out of the chain
          if (storable && (w_res != 16'd0) && (h_res != 16'd0)) begin
            if (!any_q) begin
              first_d = '{idx: cmd_i.layer, w: w_res, h: h_res};
              any_d   = 1'b1;
            end else begin
              we = 1'b1;
            end
            prev_d = cmd_i.layer[AW-1:0];
            last_d = cmd_i.layer;
          end
        end
        KIND_PALETTE: begin
          rec_n.index = {24'd0, cmd_i.holder[7:0]};
          rec_n.va    = {8'd0, cmd_i.holder[15:8]};
          rec_n.vb    = {8'd0, cmd_i.holder[23:16]};
          rec_n.vc    = cmd_i.data;
        end
        KIND_FCOUNT: begin
          rec_n.va = {8'd0, cmd_i.data};
          ftot_d   = cmd_i.data;
          frame_d  = 8'd0;
          x_d      = 16'd0;
          y_d      = 16'd0;
          pidx_d   = 32'd0;
          cur_d    = first_q;
          if ((cmd_i.data == 8'd0) || !any_q) begin
            rec_n.last = 1'b1;
            active_d   = 1'b0;
          end else begin
            active_d   = 1'b1;
          end
        end
        KIND_PIXEL: begin
          if (!active_q) begin
            // trailing byte after the last record
            emit = 1'b0;
          end else begin
            rec_n.layer = cur_q.idx;
            rec_n.frame = frame_q;
            rec_n.index = pidx_q;
            rec_n.va    = {8'd0, cmd_i.data};
            x_d         = x_q + 16'd1;
            pidx_d      = pidx_q + 32'd1;
            if (x_q + 16'd1 == cur_q.w) begin
              x_d = 16'd0;
              y_d = y_q + 16'd1;
              if (y_q + 16'd1 == cur_q.h) begin
                y_d     = 16'd0;
                pidx_d  = 32'd0;
                frame_d = frame_q + 8'd1;
                if (frame_q + 8'd1 >= ftot_q) begin
                  frame_d = 8'd0;
                  if (cur_q.idx == last_q) begin
                    rec_n.last = 1'b1;
                    active_d   = 1'b0;
                  end else begin
                    cur_d = link_next;
                  end
                end
              end
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      if (emit) begin
        out_vd = 1'b1;
        rec_d  = rec_n;
      end
    end
  end

  assign out_valid_o = out_vq;
  assign rec_o       = rec_q;

endmodule

`default_nettype wire

// ----- design/animated_palette_image_stream_parser_core.sv -----
// a byte that completes a field is queued, then its record is registered at the output
// throughput: one word per cycle while the master side is ready, set by the byte-wide
//   front parser and the link memory read, fetched ahead for the next layer with pixels
// reset: rst_ni low clears the parser phase, counters, queue and output valid at once
// the layer link memory is not cleared; every entry read is written earlier in the file
`default_nettype none

module animated_palette_image_stream_parser_core #(
  parameter int unsigned MAX_LAYERS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side: file bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] file_byte
  input  wire logic [0:0]  s_axis_tuser,  // [0] start_file
  // master side: records
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // [0] tag_match, [8:1] layer_number,
                                          // [16:9] frame_number, [48:17] item_index,
                                          // [64:49] value_a, [80:65] value_b,
                                          // [88:81] value_c, [95:89] zero
  output logic [2:0]       m_axis_tuser,  // [2:0] record_kind
  output logic             m_axis_tlast   // last_record
);

  import apisp_pkg::*;

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic back_ready;
  logic pop;
  rec_t rec;

  // the queue never fills while the back drains a word every cycle
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // front: signature check, counts, keys, resolutions, palette; pixel bytes pass through
  apisp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .start_i  (s_axis_tuser[0]),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // short queue so that a stalled master side does not stop the front at once
  apisp_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  assign pop = q_valid && back_ready;

  // back: record formatting, layer chain, pixel walk over layers and frames
  apisp_back #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_ready_o (back_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .rec_o       (rec)
  );

  // pack the record, first field lowest
  assign m_axis_tdata = {7'd0, rec.vc, rec.vb, rec.va, rec.index, rec.frame,
                         rec.layer, rec.match};
  assign m_axis_tuser = rec.kind;
  assign m_axis_tlast = rec.last;

endmodule

`default_nettype wire

// ----- design/apisp_checker.sv -----
// port-level checks of the parser core and their binding
`default_nettype none

module apisp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  import apisp_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled record changed");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("record valid right after reset");

  // the end of a file is only flagged by a frame-count or pixel record
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      (m_axis_tuser == KIND_FCOUNT) || (m_axis_tuser == KIND_PIXEL))
    else $error("last flag on a header record");

  // blue only on palette records
  a_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_PALETTE) |-> m_axis_tdata[88:81] == 8'd0)
    else $error("blue set outside a palette record");

  // frame number only on pixel records
  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_PIXEL) |-> m_axis_tdata[16:9] == 8'd0)
    else $error("frame number set outside a pixel record");

endmodule

bind animated_palette_image_stream_parser_core apisp_checker u_apisp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
